@@ hw/rtl/repeat_code_suppressor_assert.svh @@
// Assertion macros for the repeat code suppressor checker.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef REPEAT_CODE_SUPPRESSOR_ASSERT_SVH
`define REPEAT_CODE_SUPPRESSOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

@@ hw/rtl/rcs_pkg.sv @@
// Shared types and constants for the repeat code suppressor.
// No dependencies; used by the RTL modules and the testbench.
package rcs_pkg;

   localparam int CODE_W    = 31;
   localparam int AGE_W     = 24;
   localparam int SLOTS_DEF = 3;

   localparam logic [AGE_W-1:0] WAIT_RESET = AGE_W'(127000);
   localparam logic [AGE_W-1:0] AGE_MAX    = '1;

   // Values of the action field.
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_CODE = 1'b1;

   // An item as it travels down the row of cells.
   typedef struct packed {
      logic              valid;
      logic              action;   // 0 = tick, 1 = received code
      logic [CODE_W-1:0] code;
      logic              hit;      // some busy cell already holds the code
      logic              claimed;  // some free cell has reserved itself for the code
   } token_type;

   // Verdict sent to every cell when an item leaves the end of the row.
   typedef struct packed {
      logic valid;
      logic store;   // the code is new and is forwarded
   } commit_type;

endpackage

@@ hw/rtl/rcs_cell.sv @@
// One slot of the suppressor table: stored code, age counter and busy flag.
// Depends on rcs_pkg for the token and commit types.
module rcs_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rcs_pkg::AGE_W-1:0]     wait_ticks,
   input  rcs_pkg::token_type            token_in,
   output rcs_pkg::token_type            token_out,
   input  rcs_pkg::commit_type           commit
);

   logic                        busy_ff, busy_in;
   logic                        pend_ff, pend_in;
   logic [rcs_pkg::CODE_W-1:0]  value_ff, value_in;
   logic [rcs_pkg::AGE_W-1:0]   age_ff, age_in;
   logic [rcs_pkg::AGE_W-1:0]   age_inc;
   logic                        code_item;
   rcs_pkg::token_type          token_ff, token_in_nxt;

   always_comb begin
      busy_in      = busy_ff;
      pend_in      = pend_ff;
      value_in     = value_ff;
      age_in       = age_ff;
      token_in_nxt = token_in;
      age_inc      = (age_ff == rcs_pkg::AGE_MAX) ? age_ff
                                                  : rcs_pkg::AGE_W'(age_ff + 1'b1);
      code_item    = (token_in.action == rcs_pkg::ACT_CODE) && (token_in.code != '0);

      if (token_in.valid) begin
         if (token_in.action == rcs_pkg::ACT_TICK) begin
            if (busy_ff) begin
               if (age_inc >= wait_ticks) begin
                  busy_in = 1'b0;
                  age_in  = '0;
               end else begin
                  age_in = age_inc;
               end
            end
         end else if (code_item) begin
            if (busy_ff && value_ff == token_in.code) begin
               token_in_nxt.hit = 1'b1;
            end
            // The lowest free cell reserves itself; it becomes busy only if no
            // other cell turns out to hold the same code.
            if (!busy_ff && !token_in.claimed) begin
               token_in_nxt.claimed = 1'b1;
               pend_in              = 1'b1;
               value_in             = token_in.code;
            end
         end
      end

      if (commit.valid) begin
         pend_in = 1'b0;
         if (pend_ff && commit.store) begin
            busy_in = 1'b1;
            age_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         value_ff <= '0;
         age_ff   <= '0;
         token_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         pend_ff  <= pend_in;
         value_ff <= value_in;
         age_ff   <= age_in;
         token_ff <= token_in_nxt;
      end
   end

   assign token_out = token_ff;

endmodule

@@ hw/rtl/repeat_code_suppressor.sv @@
// Top level of the repeat code suppressor: a row of rcs_cell slots and the output register.
// Depends on rcs_pkg and rcs_cell.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_action, req_code
//   rsp      out        rsp_valid / rsp_stall   rsp_forwarded_code
//   csr      in         csr_valid / csr_ready   csr_wait_ticks
//
// An item walks the row of cells one cell per cycle; no new item is accepted until it has
// left the row, so the row length sets how closely items can follow each other.
// A forwarded code passes through every cell's token register and the rsp output register.
// Reset frees all slots and loads wait_ticks with 127000.
// A result held by rsp_stall blocks new items only while it is still stalled.
// A csr write takes priority over an item offered in the same cycle.
module repeat_code_suppressor #(
   parameter int SLOTS = rcs_pkg::SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [rcs_pkg::CODE_W-1:0]    req_code,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rcs_pkg::CODE_W-1:0]    rsp_forwarded_code,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rcs_pkg::AGE_W-1:0]     csr_wait_ticks
);

   rcs_pkg::token_type          chain [SLOTS+1];
   rcs_pkg::commit_type         commit;
   logic                        inflight;
   logic [rcs_pkg::AGE_W-1:0]   wait_ticks_ff, wait_ticks_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rcs_pkg::CODE_W-1:0]  rsp_code_ff, rsp_code_in;

   always_comb begin
      inflight = 1'b0;
      for (int i = 1; i <= SLOTS; i++) begin
         inflight = inflight | chain[i].valid;
      end
   end

   // Every cell must see the same wait value, so an item never enters in the
   // cycle that the register is written.
   assign req_stall = inflight || (rsp_valid_ff && rsp_stall) || csr_valid;
   assign csr_ready = !inflight;

   always_comb begin
      chain[0].valid   = req_valid && !req_stall;
      chain[0].action  = req_action;
      chain[0].code    = req_code;
      chain[0].hit     = 1'b0;
      chain[0].claimed = 1'b0;
   end

   genvar g;
   generate
      for (g = 0; g < SLOTS; g++) begin : g_cell
         rcs_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .wait_ticks (wait_ticks_ff),
            .token_in   (chain[g]),
            .token_out  (chain[g+1]),
            .commit     (commit)
         );
      end
   endgenerate

   // The item at the end of the row decides whether the reserved cell keeps the code.
   always_comb begin
      commit.valid = chain[SLOTS].valid;
      commit.store = (chain[SLOTS].action == rcs_pkg::ACT_CODE) &&
                     (chain[SLOTS].code != '0) && !chain[SLOTS].hit;
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_code_in   = rsp_code_ff;
      wait_ticks_in = wait_ticks_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (commit.valid && commit.store) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = chain[SLOTS].code;
      end
      if (csr_valid && csr_ready) begin
         wait_ticks_in = csr_wait_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         wait_ticks_ff <= rcs_pkg::WAIT_RESET;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         wait_ticks_ff <= wait_ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff <= rsp_code_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_forwarded_code = rsp_code_ff;

endmodule

@@ hw/rtl/rcs_checker.sv @@
// Port-level checks for the repeat code suppressor, bound to the top level.
// Depends on rcs_pkg and the macros in repeat_code_suppressor_assert.svh.
`include "repeat_code_suppressor_assert.svh"

module rcs_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [rcs_pkg::CODE_W-1:0]    rsp_forwarded_code
);

   // A held result keeps its value until it is taken.
   `RCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_forwarded_code))

   // A zero code is never forwarded.
   `RCS_ASSERT_NOW(a_rsp_nonzero, rsp_valid, rsp_forwarded_code != '0)

   // An accepted item occupies the row, so the next item must wait.
   `RCS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // No result can show up in the cycle right after an item is accepted.
   `RCS_ASSERT_NEXT(a_no_early_rsp, req_valid && !req_stall, !rsp_valid)

endmodule

bind repeat_code_suppressor rcs_checker u_rcs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_forwarded_code (rsp_forwarded_code)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for repeat_code_suppressor: directed rows, then random traffic
// checked against a slot-table predictor, with random idling on both channels.
// Depends on rcs_pkg and the repeat_code_suppressor RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic ACT_TICK = rcs_pkg::ACT_TICK;
   localparam logic ACT_CODE = rcs_pkg::ACT_CODE;
   localparam int   SETTLE   = 2 * (rcs_pkg::SLOTS_DEF + 1) + 2;
   localparam int   HOLD_CYCLES = 300;
   localparam int   WATCHDOG = 2000;
   localparam int   PHASE_ITEMS = 250;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FWD} row_chk_type;

   typedef struct {
      row_kind_type                kind;
      logic                        action;
      logic [rcs_pkg::CODE_W-1:0]  code;
      logic [rcs_pkg::AGE_W-1:0]   wait_val;
      row_chk_type                 chk;
      logic [rcs_pkg::CODE_W-1:0]  exp_code;
   } row_type;

   typedef struct {
      row_chk_type                 chk;
      logic [rcs_pkg::CODE_W-1:0]  exp_code;
   } plan_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_action;
   logic [rcs_pkg::CODE_W-1:0]  req_code;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [rcs_pkg::CODE_W-1:0]  rsp_forwarded_code;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [rcs_pkg::AGE_W-1:0]   csr_wait_ticks;

   // Predictor copy of the slot table and the wait register.
   logic [rcs_pkg::CODE_W-1:0]  held_code [rcs_pkg::SLOTS_DEF];
   logic [rcs_pkg::AGE_W-1:0]   held_age [rcs_pkg::SLOTS_DEF];
   bit                          held_busy [rcs_pkg::SLOTS_DEF];
   logic [rcs_pkg::AGE_W-1:0]   wait_limit;

   logic [rcs_pkg::CODE_W-1:0]  forward_q [$];
   plan_type                    plan_q [$];

   int                errors = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   bit                hold_wanted = 1'b0;
   int                quiet = 0;

   plan_type                    plan;
   logic [rcs_pkg::CODE_W-1:0]  want;
   bit                          is_new;

   // Default wait after reset is 127000 ticks, so nothing frees before the first write.
   row_type dir_rows [26] = '{
      '{ROW_ITEM, ACT_CODE, 31'd1,          24'd0,      CHK_FWD,   31'd1},
      '{ROW_ITEM, ACT_CODE, 31'd1,          24'd0,      CHK_NONE,  31'd0},
      '{ROW_ITEM, ACT_CODE, 31'd0,          24'd0,      CHK_NONE,  31'd0},
      '{ROW_ITEM, ACT_CODE, 31'h7FFFFFFF,   24'd0,      CHK_FWD,   31'h7FFFFFFF},
      '{ROW_ITEM, ACT_CODE, 31'h55555555,   24'd0,      CHK_FWD,   31'h55555555},
      '{ROW_ITEM, ACT_CODE, 31'h2AAAAAAA,   24'd0,      CHK_FWD,   31'h2AAAAAAA},
      '{ROW_ITEM, ACT_CODE, 31'h2AAAAAAA,   24'd0,      CHK_FWD,   31'h2AAAAAAA},
      '{ROW_ITEM, ACT_TICK, 31'h7FFFFFFF,   24'd0,      CHK_NONE,  31'd0},
      '{ROW_ITEM, ACT_CODE, 31'h7FFFFFFF,   24'd0,      CHK_NONE,  31'd0},
      '{ROW_CFG,  ACT_TICK, 31'd0,          24'd0,      CHK_NONE,  31'd0},
      '{ROW_ITEM, ACT_TICK, 31'd0,          24'd0,      CHK_NONE,  31'd0},
      '{ROW_ITEM, ACT_CODE, 31'h7FFFFFFF,   24'd0,      CHK_FWD,   31'h7FFFFFFF},
      '{ROW_ITEM, ACT_CODE, 31'd0,          24'd0,      CHK_NONE,  31'd0},
      '{ROW_CFG,  ACT_TICK, 31'd0,          24'd1,      CHK_NONE,  31'd0},
      '{ROW_ITEM, ACT_TICK, 31'd0,          24'd0,      CHK_NONE,  31'd0},
      '{ROW_ITEM, ACT_CODE, 31'h7FFFFFFF,   24'd0,      CHK_FWD,   31'h7FFFFFFF},
      '{ROW_CFG,  ACT_TICK, 31'd0,          24'd2,      CHK_NONE,  31'd0},
      '{ROW_ITEM, ACT_CODE, 31'h12345,      24'd0,      CHK_MODEL, 31'd0},
      '{ROW_ITEM, ACT_TICK, 31'd0,          24'd0,      CHK_MODEL, 31'd0},
      '{ROW_ITEM, ACT_CODE, 31'h12345,      24'd0,      CHK_MODEL, 31'd0},
      '{ROW_ITEM, ACT_TICK, 31'd0,          24'd0,      CHK_MODEL, 31'd0},
      '{ROW_ITEM, ACT_CODE, 31'h12345,      24'd0,      CHK_MODEL, 31'd0},
      '{ROW_CFG,  ACT_TICK, 31'd0,          24'hFFFFFF, CHK_NONE,  31'd0},
      '{ROW_ITEM, ACT_CODE, 31'd3,          24'd0,      CHK_MODEL, 31'd0},
      '{ROW_ITEM, ACT_TICK, 31'd0,          24'd0,      CHK_MODEL, 31'd0},
      '{ROW_ITEM, ACT_CODE, 31'd3,          24'd0,      CHK_MODEL, 31'd0}
   };

   repeat_code_suppressor dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_code           (req_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_forwarded_code (rsp_forwarded_code),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_wait_ticks     (csr_wait_ticks)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Updates the slot table for one item and returns 1 when the code is forwarded.
   function automatic bit predict_forward(input logic action,
                                          input logic [rcs_pkg::CODE_W-1:0] c);
      bit held;
      bit stored;
      held = 1'b0;
      stored = 1'b0;
      if (action == ACT_TICK) begin
         for (int i = 0; i < rcs_pkg::SLOTS_DEF; i++) begin
            if (held_busy[i]) begin
               if (held_age[i] != rcs_pkg::AGE_MAX) held_age[i] = held_age[i] + 1'b1;
               if (held_age[i] >= wait_limit) begin
                  held_busy[i] = 1'b0;
                  held_code[i] = '0;
                  held_age[i] = '0;
               end
            end
         end
         return 1'b0;
      end
      if (c == '0) return 1'b0;
      for (int i = 0; i < rcs_pkg::SLOTS_DEF; i++)
         if (held_busy[i] && held_code[i] == c) held = 1'b1;
      if (held) return 1'b0;
      // A full table still forwards the code; it just is not remembered.
      for (int i = 0; i < rcs_pkg::SLOTS_DEF; i++) begin
         if (!stored && !held_busy[i]) begin
            held_busy[i] = 1'b1;
            held_code[i] = c;
            held_age[i] = '0;
            stored = 1'b1;
         end
      end
      return 1'b1;
   endfunction

   // Result checking and prediction, both sampled at the clock edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (forward_q.size() == 0) begin
               $error("forwarded_code: expected no item, actual %h", rsp_forwarded_code);
               errors++;
            end else begin
               want = forward_q.pop_front();
               if (rsp_forwarded_code !== want) begin
                  $error("forwarded_code: expected %h, actual %h", want, rsp_forwarded_code);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            plan = plan_q.pop_front();
            is_new = predict_forward(req_action, req_code);
            case (plan.chk)
               CHK_FWD: forward_q.push_back(plan.exp_code);
               CHK_MODEL: begin
                  if (is_new) forward_q.push_back(req_code);
               end
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet == WATCHDOG) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_item(input logic action, input logic [rcs_pkg::CODE_W-1:0] c,
                            input row_chk_type chk,
                            input logic [rcs_pkg::CODE_W-1:0] exp_code);
      plan_type p;
      p.chk = chk;
      p.exp_code = exp_code;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      plan_q.push_back(p);
      req_valid <= 1'b1;
      req_action <= action;
      req_code <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Waits until every expected item has come out and the row of cells has emptied.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (forward_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_wait(input logic [rcs_pkg::AGE_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_wait_ticks <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      wait_limit = v;
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
         default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
   endtask

   initial begin
      logic [rcs_pkg::CODE_W-1:0] pool [5];
      logic [rcs_pkg::CODE_W-1:0] c;
      logic [rcs_pkg::AGE_W-1:0]  w;
      logic                       action;
      int                         pick;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= 1'b0;
      req_code <= '0;
      csr_valid <= 1'b0;
      csr_wait_ticks <= '0;
      wait_limit = rcs_pkg::WAIT_RESET;
      for (int i = 0; i < rcs_pkg::SLOTS_DEF; i++) begin
         held_code[i] = '0;
         held_age[i] = '0;
         held_busy[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_CFG)
            set_wait(dir_rows[r].wait_val);
         else
            send_item(dir_rows[r].action, dir_rows[r].code, dir_rows[r].chk,
                      dir_rows[r].exp_code);
      end

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: w = rcs_pkg::AGE_W'(3);
            1: w = rcs_pkg::AGE_W'(8);
            2: w = rcs_pkg::AGE_W'($urandom_range(1, 40));
            3: w = '0;
            4: w = rcs_pkg::AGE_MAX;
            default: w = rcs_pkg::AGE_W'($urandom);
         endcase
         set_wait(w);
         // A handful of codes per phase, so that repeats are common.
         foreach (pool[k]) pool[k] = rcs_pkg::CODE_W'($urandom);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % (PHASE_ITEMS / 2) == 0) set_idling((ph * 2 + n / (PHASE_ITEMS / 2)) % 4);
            if (ph == 1 && n == 60) hold_wanted = 1'b1;
            if (ph == 2 && n == PHASE_ITEMS / 2) drain();
            pick = $urandom_range(99);
            action = ACT_CODE;
            if (pick < 30) begin
               action = ACT_TICK;
               c = rcs_pkg::CODE_W'($urandom);
            end else if (pick < 35) begin
               c = '0;
            end else if (pick < 40) begin
               c = rcs_pkg::CODE_W'($urandom);
            end else begin
               c = pool[$urandom_range(4)];
            end
            send_item(action, c, CHK_MODEL, '0);
         end
      end

      drain();
      if (forward_q.size() != 0) begin
         $error("forwarded_code: %0d expected items never arrived", forward_q.size());
         errors++;
      end
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
